@@ rtl/core/hpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants shared by the position table front end, command
// queue and back end.
// ----------------------------------------------------------------------------
package hpt_pkg;

    // Operation codes; the input kind field uses the same encoding.
    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Bound code that carries no bound; such a store always overwrites.
    localparam logic [1:0] BOUND_NONE = 2'd0;

    // Scores beyond this magnitude are mate scores and get the ply adjustment.
    localparam logic signed [15:0] MATE_EDGE     = 16'sd29000;
    localparam logic signed [15:0] MATE_EDGE_NEG = -16'sd29000;
    localparam logic signed [16:0] SCORE_MAX     = 17'sd32767;
    localparam logic signed [16:0] SCORE_MIN     = -17'sd32768;

    // Depth of the queue between front and back end.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Best move as stored in an entry.
    typedef struct packed {
        logic [5:0] from_sq;
        logic [5:0] to_sq;
        logic       promotes;
        logic [3:0] promo_piece;
        logic       castles;
        logic       captures;
    } t_move;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_op               op;
        logic [63:0]       key;
        logic [6:0]        depth;
        logic signed [15:0] score;
        logic [1:0]        bound;
        logic [5:0]        ply;
        t_move             move;
    } t_cmd;

    // One table entry.
    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        t_move              move;
    } t_entry;

    // One probe result.
    typedef struct packed {
        logic               hit;
        logic [6:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        t_move              move;
    } t_result;

    // Back end states.
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } t_back_state;

    // Status reported by the back end to the front end.
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_status;

endpackage

@@ rtl/core/hpt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_front
// Accepts input items, classifies them by kind, applies the mate score
// adjustment for stores and holds the resulting command for the queue.
// ----------------------------------------------------------------------------
module hpt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_kind,
    input  logic [63:0]         i_key,
    input  logic [6:0]          i_depth,
    input  logic signed [15:0]  i_score,
    input  logic [1:0]          i_bound,
    input  logic [5:0]          i_ply,
    input  hpt_pkg::t_move      i_move,
    input  hpt_pkg::t_back_status i_status,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output hpt_pkg::t_cmd       o_cmd
);

    logic               r_valid;
    logic               n_valid;
    hpt_pkg::t_cmd      r_cmd;
    hpt_pkg::t_cmd      n_cmd;
    logic               accept;
    logic               keep_item;
    logic signed [16:0] score_ext;
    logic signed [16:0] ply_ext;
    logic signed [16:0] score_sum;
    logic signed [15:0] store_score;

    // No transfer while the table is being swept.
    assign o_ready     = (!r_valid || i_cmd_ready) && !i_status.clearing;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Mate scores are pushed away from zero by ply and saturated to 16 bits.
    assign score_ext = {i_score[15], i_score};
    assign ply_ext   = {11'b0, i_ply};

    always_comb begin
        score_sum   = score_ext;
        store_score = i_score;
        if (i_score > hpt_pkg::MATE_EDGE) begin
            score_sum = score_ext + ply_ext;
            if (score_sum > hpt_pkg::SCORE_MAX) begin
                score_sum = hpt_pkg::SCORE_MAX;
            end
        end else if (i_score < hpt_pkg::MATE_EDGE_NEG) begin
            score_sum = score_ext - ply_ext;
            if (score_sum < hpt_pkg::SCORE_MIN) begin
                score_sum = hpt_pkg::SCORE_MIN;
            end
        end
        store_score = score_sum[15:0];
    end

    // Classify the item; the unused kind is dropped here.
    always_comb begin
        keep_item   = 1'b1;
        n_cmd.op    = hpt_pkg::OP_PROBE;
        n_cmd.key   = i_key;
        n_cmd.depth = i_depth;
        n_cmd.score = i_score;
        n_cmd.bound = i_bound;
        n_cmd.ply   = i_ply;
        n_cmd.move  = i_move;
        case (i_kind)
            hpt_pkg::OP_PROBE: begin
                n_cmd.op = hpt_pkg::OP_PROBE;
            end
            hpt_pkg::OP_STORE: begin
                n_cmd.op    = hpt_pkg::OP_STORE;
                n_cmd.score = store_score;
            end
            hpt_pkg::OP_CLEAR: begin
                n_cmd.op = hpt_pkg::OP_CLEAR;
            end
            default: begin
                keep_item = 1'b0;
            end
        endcase
    end

    // Holding register in front of the queue.
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = keep_item;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ rtl/core/hpt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module hpt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  hpt_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output hpt_pkg::t_cmd o_pop_data
);

    localparam int unsigned CNT_W = $clog2(hpt_pkg::QUEUE_DEPTH + 1);

    hpt_pkg::t_cmd                   r_slot [hpt_pkg::QUEUE_DEPTH];
    logic [hpt_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [hpt_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]                r_count;
    logic [hpt_pkg::QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [hpt_pkg::QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0]                n_count;
    logic                            push;
    logic                            pop;

    assign o_push_ready = (r_count != CNT_W'(hpt_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and count update with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            if (r_wr_ptr == hpt_pkg::QUEUE_PTR_W'(hpt_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
        end
        if (pop) begin
            if (r_rd_ptr == hpt_pkg::QUEUE_PTR_W'(hpt_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/hpt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_back
// Owns the entry memory: sweeps it clear, performs the read, compare and
// write of each probe or store, and holds probe results for the output.
// ----------------------------------------------------------------------------
module hpt_back #(
    parameter int unsigned TABLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  hpt_pkg::t_cmd         i_cmd,
    output hpt_pkg::t_back_status o_status,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hpt_pkg::t_result      o_result
);

    localparam int unsigned TABLE_SIZE = 2 ** TABLE_BITS;

    hpt_pkg::t_entry        r_mem [TABLE_SIZE];
    hpt_pkg::t_entry        r_rd_data;
    hpt_pkg::t_back_state   r_state;
    hpt_pkg::t_back_state   n_state;
    logic [TABLE_BITS-1:0]  r_clr_addr;
    logic [TABLE_BITS-1:0]  n_clr_addr;
    hpt_pkg::t_cmd          r_cmd;
    logic                   r_out_valid;
    logic                   n_out_valid;
    hpt_pkg::t_result       r_out;
    hpt_pkg::t_result       n_out;
    logic                   load_cmd;
    logic                   rd_en;
    logic                   wr_en;
    logic [TABLE_BITS-1:0]  wr_addr;
    hpt_pkg::t_entry        wr_data;
    logic                   hit;
    logic                   keep_old;
    logic signed [15:0]     probe_score;
    logic                   out_free;

    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign o_cmd_ready = (r_state == hpt_pkg::ST_IDLE);
    assign o_status.clearing = (r_state == hpt_pkg::ST_CLEAR);
    assign o_status.idle     = (r_state == hpt_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || i_ready;

    // Hit check against the entry that was read for the current command.
    assign hit      = r_rd_data.valid && (r_rd_data.key == r_cmd.key);
    assign keep_old = hit && (r_rd_data.depth > r_cmd.depth) &&
                      (r_cmd.bound != hpt_pkg::BOUND_NONE);

    // Mate scores are brought back toward zero by ply on the way out.
    always_comb begin
        probe_score = r_rd_data.score;
        if (r_rd_data.score > hpt_pkg::MATE_EDGE) begin
            probe_score = r_rd_data.score - $signed({10'b0, r_cmd.ply});
        end else if (r_rd_data.score < hpt_pkg::MATE_EDGE_NEG) begin
            probe_score = r_rd_data.score + $signed({10'b0, r_cmd.ply});
        end
    end

    // Next state, memory controls and output register.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        load_cmd    = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_cmd.key[TABLE_BITS-1:0];
        wr_data     = '0;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        case (r_state)
            hpt_pkg::ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {TABLE_BITS{1'b1}}) begin
                    n_state = hpt_pkg::ST_IDLE;
                end
            end
            hpt_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == hpt_pkg::OP_CLEAR) begin
                        n_clr_addr = '0;
                        n_state    = hpt_pkg::ST_CLEAR;
                    end else begin
                        load_cmd = 1'b1;
                        rd_en    = 1'b1;
                        n_state  = hpt_pkg::ST_LOOKUP;
                    end
                end
            end
            hpt_pkg::ST_LOOKUP: begin
                if (r_cmd.op == hpt_pkg::OP_STORE) begin
                    wr_en         = !keep_old;
                    wr_data.valid = 1'b1;
                    wr_data.key   = r_cmd.key;
                    wr_data.depth = r_cmd.depth;
                    wr_data.score = r_cmd.score;
                    wr_data.bound = r_cmd.bound;
                    wr_data.move  = r_cmd.move;
                    n_state       = hpt_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (hit) begin
                        n_out.hit   = 1'b1;
                        n_out.depth = r_rd_data.depth;
                        n_out.score = probe_score;
                        n_out.bound = r_rd_data.bound;
                        n_out.move  = r_rd_data.move;
                    end
                    n_state = hpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hpt_pkg::ST_IDLE;
            end
        endcase
    end

    // A sweep of the whole table follows reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpt_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (load_cmd) begin
            r_cmd <= i_cmd;
        end
    end

    // Entry memory: one registered read port and one write port.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[i_cmd.key[TABLE_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

endmodule

@@ rtl/core/hash_position_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_position_table
// Direct-mapped position table: probe, store and clear of entries indexed
// by the low bits of a 64-bit key.
// ----------------------------------------------------------------------------
// A probe or a store passes the back end as the registered memory read and
// then the key compare and the write or the result. The entry memory has a
// single read port, and the back end takes no new command until it is through
// with the last one; a probe also waits until the result register is free. A
// probe result passes the input register, the command queue, the memory read
// and the result register. A clear, and the sweep that follows reset, write
// one entry per cycle over the whole table; no input transfer is taken while
// the sweep runs.
module hash_position_table #(
    parameter int unsigned TABLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [63:0]        i_key,
    input  logic [6:0]         i_depth,
    input  logic signed [15:0] i_score,
    input  logic [1:0]         i_bound,
    input  logic [5:0]         i_ply,
    input  logic [5:0]         i_move_from,
    input  logic [5:0]         i_move_to,
    input  logic               i_move_promotes,
    input  logic [3:0]         i_move_promo_piece,
    input  logic               i_move_castles,
    input  logic               i_move_captures,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [6:0]         o_found_depth,
    output logic signed [15:0] o_found_score,
    output logic [1:0]         o_found_bound,
    output logic [5:0]         o_found_from,
    output logic [5:0]         o_found_to,
    output logic               o_found_promotes,
    output logic [3:0]         o_found_promo_piece,
    output logic               o_found_castles,
    output logic               o_found_captures
);

    hpt_pkg::t_move        in_move;
    hpt_pkg::t_back_status status;
    hpt_pkg::t_cmd         front_cmd;
    logic                  front_valid;
    logic                  front_ready;
    hpt_pkg::t_cmd         queue_cmd;
    logic                  queue_valid;
    logic                  queue_ready;
    hpt_pkg::t_result      result;

    // Gather the move fields into one word.
    assign in_move.from_sq     = i_move_from;
    assign in_move.to_sq       = i_move_to;
    assign in_move.promotes    = i_move_promotes;
    assign in_move.promo_piece = i_move_promo_piece;
    assign in_move.castles     = i_move_castles;
    assign in_move.captures    = i_move_captures;

    hpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_depth     (i_depth),
        .i_score     (i_score),
        .i_bound     (i_bound),
        .i_ply       (i_ply),
        .i_move      (in_move),
        .i_status    (status),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    hpt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_cmd)
    );

    hpt_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    // Spread the result word over the output ports.
    assign o_hit               = result.hit;
    assign o_found_depth       = result.depth;
    assign o_found_score       = result.score;
    assign o_found_bound       = result.bound;
    assign o_found_from        = result.move.from_sq;
    assign o_found_to          = result.move.to_sq;
    assign o_found_promotes    = result.move.promotes;
    assign o_found_promo_piece = result.move.promo_piece;
    assign o_found_castles     = result.move.castles;
    assign o_found_captures    = result.move.captures;

endmodule

@@ tb/sv/tb_hash_position_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_position_table
// Self-checking bench for the direct-mapped position table. A short table of
// directed requests covers the empty table, field extremes, mate-score
// adjustment, saturation, index collisions, the deeper-entry guard, the
// unused kind and a clear. A long random phase follows, built around a small
// pool of keys that share a few table indexes. A shadow copy of the table
// predicts every probe result not typed in the directed table. Both handshakes
// are throttled at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_hash_position_table;

    localparam int TB_TABLE_BITS    = 16;
    localparam int TABLE_ENTRIES    = 1 << TB_TABLE_BITS;
    localparam int RANDOM_ITEMS     = 900;
    localparam int QUIET_TAIL_ITEMS = 100;
    localparam int KEY_POOL_SIZE    = 24;
    localparam int CLEAR_BUDGET     = 4;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 64;
    // The reset sweep and every clear, each over the whole table, dominate the run.
    localparam int RUN_LIMIT_NS     = 25_000_000;

    localparam int MATE_SCORE_EDGE = 29000;
    localparam int SCORE_CEIL      = 32767;
    localparam int SCORE_FLOOR     = -32768;

    // Kind code that the block must take and ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam logic [63:0] KEY_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_A    = 64'h1234_5678_9ABC_0001;
    localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_0001;
    localparam logic [63:0] KEY_C    = 64'h8000_0000_0000_0002;
    localparam logic [63:0] KEY_D    = 64'h0000_0000_0001_0003;

    localparam hpt_pkg::t_move   MOVE_NONE   = '0;
    localparam hpt_pkg::t_move   MOVE_ALL    = '1;
    localparam hpt_pkg::t_move   MOVE_MIX    = '{from_sq: 6'd12, to_sq: 6'd52,
                                                 promotes: 1'b1, promo_piece: 4'd5,
                                                 castles: 1'b0, captures: 1'b1};
    localparam hpt_pkg::t_result MISS_RESULT = '0;

    typedef struct {
        logic [1:0]         kind;
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [5:0]         ply;
        hpt_pkg::t_move     move;
    } t_request;

    typedef struct {
        t_request         req;
        bit               typed;
        hpt_pkg::t_result want;
    } t_row;

    logic               i_clk;
    logic               rst_n;
    logic               tx_valid;
    logic               blk_ready;
    logic [1:0]         tx_kind;
    logic [63:0]        tx_key;
    logic [6:0]         tx_depth;
    logic signed [15:0] tx_score;
    logic [1:0]         tx_bound;
    logic [5:0]         tx_ply;
    logic [5:0]         tx_move_from;
    logic [5:0]         tx_move_to;
    logic               tx_move_promotes;
    logic [3:0]         tx_move_promo_piece;
    logic               tx_move_castles;
    logic               tx_move_captures;
    logic               rslt_valid;
    logic               rx_ready;
    logic               o_hit;
    logic [6:0]         o_found_depth;
    logic signed [15:0] o_found_score;
    logic [1:0]         o_found_bound;
    logic [5:0]         o_found_from;
    logic [5:0]         o_found_to;
    logic               o_found_promotes;
    logic [3:0]         o_found_promo_piece;
    logic               o_found_castles;
    logic               o_found_captures;

    // Shadow copy of the table and the probe results still owed by the block.
    hpt_pkg::t_entry  shadow_entries [TABLE_ENTRIES];
    hpt_pkg::t_result pending_results [$];

    // Directed stimulus, in the order it is sent.
    t_row directed_rows [$];

    int error_count   = 0;
    int checked_count = 0;
    int probe_count   = 0;
    int hit_count     = 0;
    int store_count   = 0;
    int refused_count = 0;
    int clear_count   = 0;
    int unused_count  = 0;

    bit quiet_tail       = 1'b0;
    bit hold_off_request = 1'b0;
    int tx_pace_left     = 0;
    int tx_gap_chance    = 0;

    hash_position_table #(
        .TABLE_BITS(TB_TABLE_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_valid            (tx_valid),
        .o_ready            (blk_ready),
        .i_kind             (tx_kind),
        .i_key              (tx_key),
        .i_depth            (tx_depth),
        .i_score            (tx_score),
        .i_bound            (tx_bound),
        .i_ply              (tx_ply),
        .i_move_from        (tx_move_from),
        .i_move_to          (tx_move_to),
        .i_move_promotes    (tx_move_promotes),
        .i_move_promo_piece (tx_move_promo_piece),
        .i_move_castles     (tx_move_castles),
        .i_move_captures    (tx_move_captures),
        .o_valid            (rslt_valid),
        .i_ready            (rx_ready),
        .o_hit              (o_hit),
        .o_found_depth      (o_found_depth),
        .o_found_score      (o_found_score),
        .o_found_bound      (o_found_bound),
        .o_found_from       (o_found_from),
        .o_found_to         (o_found_to),
        .o_found_promotes   (o_found_promotes),
        .o_found_promo_piece(o_found_promo_piece),
        .o_found_castles    (o_found_castles),
        .o_found_captures   (o_found_captures)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one accepted request to the shadow table; returns 1 when the
    // request owes a probe result, which is left in res.
    function automatic bit apply_table_access(input t_request r,
                                              output hpt_pkg::t_result res);
        hpt_pkg::t_entry          slot;
        int                       s;
        logic [TB_TABLE_BITS-1:0] idx;
        res  = '0;
        idx  = r.key[TB_TABLE_BITS-1:0];
        slot = shadow_entries[idx];
        case (r.kind)
            hpt_pkg::OP_PROBE: begin
                probe_count++;
                if (slot.valid && slot.key == r.key) begin
                    // Mate scores come back toward zero by the probing ply.
                    s = $signed(slot.score);
                    if (s > MATE_SCORE_EDGE) begin
                        s = s - int'(r.ply);
                    end else if (s < -MATE_SCORE_EDGE) begin
                        s = s + int'(r.ply);
                    end
                    res.hit   = 1'b1;
                    res.depth = slot.depth;
                    res.score = 16'(s);
                    res.bound = slot.bound;
                    res.move  = slot.move;
                    hit_count++;
                end
                return 1'b1;
            end
            hpt_pkg::OP_STORE: begin
                store_count++;
                // Mate scores move away from zero by ply, then clamp to 16 bits.
                s = $signed(r.score);
                if (s > MATE_SCORE_EDGE) begin
                    s = s + int'(r.ply);
                end else if (s < -MATE_SCORE_EDGE) begin
                    s = s - int'(r.ply);
                end
                if (s > SCORE_CEIL) begin
                    s = SCORE_CEIL;
                end else if (s < SCORE_FLOOR) begin
                    s = SCORE_FLOOR;
                end
                // A deeper entry for the same key survives a bounded store.
                if (slot.valid && slot.key == r.key && slot.depth > r.depth &&
                    r.bound != hpt_pkg::BOUND_NONE) begin
                    refused_count++;
                end else begin
                    slot.valid = 1'b1;
                    slot.key   = r.key;
                    slot.depth = r.depth;
                    slot.score = 16'(s);
                    slot.bound = r.bound;
                    slot.move  = r.move;
                    shadow_entries[idx] = slot;
                end
            end
            hpt_pkg::OP_CLEAR: begin
                clear_count++;
                foreach (shadow_entries[i]) shadow_entries[i] = '0;
            end
            default: begin
                // The unused kind leaves the table alone.
                unused_count++;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_row command_row(input logic [1:0] kind, input logic [63:0] key,
                                         input logic [6:0] depth,
                                         input logic signed [15:0] score,
                                         input logic [1:0] bound, input logic [5:0] ply,
                                         input hpt_pkg::t_move move);
        t_row row;
        row.req.kind  = kind;
        row.req.key   = key;
        row.req.depth = depth;
        row.req.score = score;
        row.req.bound = bound;
        row.req.ply   = ply;
        row.req.move  = move;
        row.typed     = PREDICTED;
        row.want      = MISS_RESULT;
        return row;
    endfunction

    function automatic t_row probe_row(input logic [63:0] key, input logic [5:0] ply,
                                       input bit typed, input hpt_pkg::t_result want);
        t_row row;
        row       = command_row(hpt_pkg::OP_PROBE, key, 7'd0, 16'sd0, hpt_pkg::BOUND_NONE,
                                ply, MOVE_NONE);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Appends one row to the directed table.
    function automatic void queue_row(input t_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Keys in the pool share six table indexes so collisions are common.
    function automatic logic [63:0] fresh_pool_key();
        logic [63:0] k;
        logic [31:0] idx_bits;
        k        = {$urandom, $urandom};
        idx_bits = $urandom_range(0, 5) * 32'h0000_9E37;
        k[TB_TABLE_BITS-1:0] = idx_bits[TB_TABLE_BITS-1:0];
        return k;
    endfunction

    // Drives one request after an optional gap, waits for its transfer and
    // records the result it owes.
    task automatic offer_request(input t_request r, input bit typed,
                                 input hpt_pkg::t_result want);
        hpt_pkg::t_result predicted;
        int               gap;
        if (tx_pace_left == 0) begin
            tx_pace_left  = 48;
            tx_gap_chance = $urandom_range(0, 3);
        end
        tx_pace_left--;
        gap = 0;
        if (!quiet_tail && tx_gap_chance != 0 && $urandom_range(0, 7) < tx_gap_chance) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            tx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        tx_kind             <= r.kind;
        tx_key              <= r.key;
        tx_depth            <= r.depth;
        tx_score            <= r.score;
        tx_bound            <= r.bound;
        tx_ply              <= r.ply;
        tx_move_from        <= r.move.from_sq;
        tx_move_to          <= r.move.to_sq;
        tx_move_promotes    <= r.move.promotes;
        tx_move_promo_piece <= r.move.promo_piece;
        tx_move_castles     <= r.move.castles;
        tx_move_captures    <= r.move.captures;
        tx_valid            <= 1'b1;
        do @(posedge i_clk); while (!blk_ready);
        if (apply_table_access(r, predicted)) begin
            pending_results.insert(pending_results.size(), typed ? want : predicted);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expected,
                               input logic signed [31:0] actual);
        if (actual !== expected) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
        end
    endtask

    // Receiver pacing: random stall bursts, calm stretches, and one long
    // hold-off on request while the sender keeps offering.
    initial begin : receiver_pacing
        int stall_left;
        int pace_left;
        int stall_chance;
        stall_left   = 0;
        pace_left    = 0;
        stall_chance = 0;
        rx_ready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                rx_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_request = 1'b0;
                rx_ready <= 1'b1;
            end else begin
                if (pace_left == 0) begin
                    pace_left    = 64;
                    stall_chance = $urandom_range(0, 3);
                end
                pace_left--;
                if (stall_left == 0 && !quiet_tail && stall_chance != 0 &&
                    $urandom_range(0, 15) < stall_chance) begin
                    stall_left = $urandom_range(1, 6);
                end
                if (stall_left > 0) begin
                    rx_ready <= 1'b0;
                    stall_left--;
                end else begin
                    rx_ready <= 1'b1;
                end
            end
        end
    end

    // Each result transfer is matched against the oldest owed probe result.
    always @(posedge i_clk) begin : result_check
        hpt_pkg::t_result want;
        if (rst_n && rslt_valid && rx_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transfer, expected none, actual hit %0d",
                         $time, o_hit);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                check_field("hit", want.hit, o_hit);
                check_field("found_depth", want.depth, o_found_depth);
                check_field("found_score", want.score, o_found_score);
                check_field("found_bound", want.bound, o_found_bound);
                check_field("found_from", want.move.from_sq, o_found_from);
                check_field("found_to", want.move.to_sq, o_found_to);
                check_field("found_promotes", want.move.promotes, o_found_promotes);
                check_field("found_promo_piece", want.move.promo_piece, o_found_promo_piece);
                check_field("found_castles", want.move.castles, o_found_castles);
                check_field("found_captures", want.move.captures, o_found_captures);
            end
        end
    end

    // Watchdog.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d probe results still owed", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence: reset, directed table, random phase, drain, verdict.
    initial begin : stimulus
        t_request    r;
        logic [63:0] key_pool [KEY_POOL_SIZE];
        logic [31:0] rnd;
        int          sel;
        int          s;
        int          counted;
        int          clears_left;

        rst_n               = 1'b0;
        tx_valid            = 1'b0;
        tx_kind             = hpt_pkg::OP_PROBE;
        tx_key              = '0;
        tx_depth            = '0;
        tx_score            = '0;
        tx_bound            = '0;
        tx_ply              = '0;
        tx_move_from        = '0;
        tx_move_to          = '0;
        tx_move_promotes    = 1'b0;
        tx_move_promo_piece = '0;
        tx_move_castles     = 1'b0;
        tx_move_captures    = 1'b0;
        foreach (shadow_entries[i]) shadow_entries[i] = '0;
        foreach (key_pool[i]) key_pool[i] = fresh_pool_key();

        repeat (2) @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed table. Probes with a typed result are checked against it.
        // Empty table: key zero must miss.
        queue_row(probe_row(KEY_ZERO, 6'd0, TYPED, MISS_RESULT));
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_ZERO, 7'd0, 16'sd0, 2'd0, 6'd0,
                              MOVE_NONE));
        queue_row(probe_row(KEY_ZERO, 6'd0, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd0, 16'sd0, 2'd0, MOVE_NONE}));
        // Field maxima, with a mate score pushed out by the full ply.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_ONES, 7'd127, 16'sd32000, 2'd3,
                              6'd63, MOVE_ALL));
        queue_row(probe_row(KEY_ONES, 6'd0, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd127, 16'sd32063, 2'd3, MOVE_ALL}));
        queue_row(probe_row(KEY_ONES, 6'd63, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd127, 16'sd32000, 2'd3, MOVE_ALL}));
        // Shallower bounded store is refused; a zero bound overwrites.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_ONES, 7'd5, 16'sd100, 2'd2, 6'd0,
                              MOVE_MIX));
        queue_row(probe_row(KEY_ONES, 6'd0, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd127, 16'sd32063, 2'd3, MOVE_ALL}));
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_ONES, 7'd5, -16'sd100, 2'd0, 6'd63,
                              MOVE_NONE));
        queue_row(probe_row(KEY_ONES, 6'd63, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd5, -16'sd100, 2'd0, MOVE_NONE}));
        // Negative mate score, then a colliding key that evicts it.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_A, 7'd64, -16'sd32000, 2'd1, 6'd63,
                              MOVE_MIX));
        queue_row(probe_row(KEY_A, 6'd10, PREDICTED, MISS_RESULT));
        queue_row(probe_row(KEY_B, 6'd0, TYPED, MISS_RESULT));
        // Positive saturation on store.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_B, 7'd10, 16'sd32767, 2'd2, 6'd1,
                              MOVE_ALL));
        queue_row(probe_row(KEY_B, 6'd0, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd10, 16'sd32767, 2'd2, MOVE_ALL}));
        queue_row(probe_row(KEY_A, 6'd0, TYPED, MISS_RESULT));
        // Negative saturation on store.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_C, 7'd1, -16'sd32768, 2'd3, 6'd5,
                              MOVE_NONE));
        queue_row(probe_row(KEY_C, 6'd63, TYPED,
                            hpt_pkg::t_result'{1'b1, 7'd1, -16'sd32705, 2'd3, MOVE_NONE}));
        // Scores at the mate edge; an equal-depth bounded store overwrites.
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_D, 7'd30, 16'sd29000, 2'd3, 6'd20,
                              MOVE_MIX));
        queue_row(probe_row(KEY_D, 6'd20, PREDICTED, MISS_RESULT));
        queue_row(command_row(hpt_pkg::OP_STORE, KEY_D, 7'd30, -16'sd29001, 2'd1, 6'd1,
                              MOVE_ALL));
        queue_row(probe_row(KEY_D, 6'd1, PREDICTED, MISS_RESULT));
        // Unused kind, then a clear that must empty everything.
        queue_row(command_row(KIND_UNUSED, KEY_D, 7'd0, 16'sd0, 2'd0, 6'd0, MOVE_NONE));
        queue_row(command_row(hpt_pkg::OP_CLEAR, KEY_ZERO, 7'd0, 16'sd0, 2'd0, 6'd0,
                              MOVE_NONE));
        queue_row(probe_row(KEY_ZERO, 6'd0, TYPED, MISS_RESULT));
        queue_row(probe_row(KEY_ONES, 6'd63, TYPED, MISS_RESULT));

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phase: mostly stores and probes over the shared key pool.
        hold_off_request = 1'b1;
        clears_left      = CLEAR_BUDGET;
        counted          = 0;
        while (counted < RANDOM_ITEMS) begin
            quiet_tail = (counted >= RANDOM_ITEMS - QUIET_TAIL_ITEMS);
            if ($urandom_range(0, 31) == 0) begin
                key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = fresh_pool_key();
            end
            rnd     = $urandom;
            r.kind  = hpt_pkg::OP_STORE;
            r.key   = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            r.bound = rnd[20:19];
            r.move  = rnd[18:0];
            r.ply   = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0: r.depth = 7'd0;
                1: r.depth = 7'd127;
                default: r.depth = 7'($urandom_range(0, 127));
            endcase

            sel = $urandom_range(0, 999);
            if (sel < 450) begin
                r.kind = hpt_pkg::OP_PROBE;
            end else if (sel < 520) begin
                r.kind = hpt_pkg::OP_PROBE;
                r.key  = {$urandom, $urandom};
            end else if (sel < 900) begin
                r.kind = hpt_pkg::OP_STORE;
            end else if (sel < 940) begin
                r.key = {$urandom, $urandom};
            end else if (sel < 965) begin
                r.kind = KIND_UNUSED;
            end else if (sel < 969 && clears_left > 0) begin
                r.kind = hpt_pkg::OP_CLEAR;
                clears_left--;
            end

            // Scores weighted toward the mate range and its edge.
            case ($urandom_range(0, 9))
                0, 1:    s = int'($urandom_range(0, 64000)) - 32000;
                2, 3, 4: s = int'($urandom_range(29001, 32000));
                5:       s = int'($urandom_range(28995, 29005));
                6:       s = int'($urandom_range(0, 65535)) - 32768;
                7: begin
                    case ($urandom_range(0, 2))
                        0:       s = SCORE_CEIL;
                        1:       s = SCORE_FLOOR;
                        default: s = 32000;
                    endcase
                end
                default: s = int'($urandom_range(0, 1000)) - 500;
            endcase
            if ($urandom_range(0, 1) == 1) begin
                s = -s;
            end
            r.score = 16'(s);

            offer_request(r, PREDICTED, MISS_RESULT);
            if (r.kind != KIND_UNUSED) begin
                counted++;
            end
        end

        @(negedge i_clk);
        tx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d probes (%0d hits), %0d stores (%0d refused by a deeper entry),",
                 probe_count, hit_count, store_count, refused_count);
        $display("%0d clears and %0d unused-kind transfers; %0d results compared.",
                 clear_count, unused_count, checked_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
